### sv/sfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_pkg: shared types and codes for the stuffed frame receiver
// Register indexes, result kinds, phase encoding and the token and result
// structs passed between the front end, the token queue and the engine.
// ----------------------------------------------------------------------------
package sfr_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_FLAG_CODE      = 3'd0;
    localparam logic [2:0] CFG_ESCAPE_CODE    = 3'd1;
    localparam logic [2:0] CFG_STUF_FLAG_CODE = 3'd2;
    localparam logic [2:0] CFG_STUF_ESC_CODE  = 3'd3;
    localparam logic [2:0] CFG_SENDER_ADDR    = 3'd4;
    localparam logic [2:0] CFG_CTRL_EVEN      = 3'd5;
    localparam logic [2:0] CFG_CTRL_ODD       = 3'd6;

    localparam logic [7:0] RST_FLAG_CODE      = 8'd126;
    localparam logic [7:0] RST_ESCAPE_CODE    = 8'd125;
    localparam logic [7:0] RST_STUF_FLAG_CODE = 8'd94;
    localparam logic [7:0] RST_STUF_ESC_CODE  = 8'd93;
    localparam logic [7:0] RST_SENDER_ADDR    = 8'd3;
    localparam logic [7:0] RST_CTRL_EVEN      = 8'd0;
    localparam logic [7:0] RST_CTRL_ODD       = 8'd64;

    typedef enum logic [2:0] {
        KIND_PAYLOAD   = 3'd0,
        KIND_GOOD_NEW  = 3'd1,
        KIND_GOOD_DUP  = 3'd2,
        KIND_BAD_CHECK = 3'd3,
        KIND_ESC_ERROR = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_FLAG = 3'd1,
        PH_ADDR = 3'd2,
        PH_CTRL = 3'd3,
        PH_BODY = 3'd4,
        PH_ESC  = 3'd5
    } phase_t;

    typedef struct packed {
        logic [7:0] flag_code;
        logic [7:0] escape_code;
        logic [7:0] stuf_flag_code;
        logic [7:0] stuf_esc_code;
        logic [7:0] sender_addr;
        logic [7:0] ctrl_even;
        logic [7:0] ctrl_odd;
    } cfg_t;

    // one classified line byte
    typedef struct packed {
        logic [7:0] data;
        logic       is_flag;
        logic       is_escape;
        logic       is_addr;
        logic       is_ctrl_even;
        logic       is_ctrl_odd;
        logic       is_hdr_even;
        logic       is_hdr_odd;
        logic       is_stuf_flag;
        logic       is_stuf_esc;
    } tok_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data_byte;
        logic       seq_bit;
        logic       send_reply;
        logic       reply_is_reject;
        logic       last;
    } res_t;

endpackage

### sv/sfr_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_classifier: front-end byte classifier
// Compares a raw line byte against every configured code and the two
// possible header check values, producing a token for the engine.
// ----------------------------------------------------------------------------
module sfr_classifier
    import sfr_pkg::*;
(
    input  logic [7:0] rx_byte,
    input  cfg_t       cfg,
    output tok_t       tok
);

    logic [7:0] hdr_even;
    logic [7:0] hdr_odd;

    assign hdr_even = cfg.sender_addr ^ cfg.ctrl_even;
    assign hdr_odd  = cfg.sender_addr ^ cfg.ctrl_odd;

    always_comb begin
        tok.data         = rx_byte;
        tok.is_flag      = (rx_byte == cfg.flag_code);
        tok.is_escape    = (rx_byte == cfg.escape_code);
        tok.is_addr      = (rx_byte == cfg.sender_addr);
        tok.is_ctrl_even = (rx_byte == cfg.ctrl_even);
        tok.is_ctrl_odd  = (rx_byte == cfg.ctrl_odd);
        tok.is_hdr_even  = (rx_byte == hdr_even);
        tok.is_hdr_odd   = (rx_byte == hdr_odd);
        tok.is_stuf_flag = (rx_byte == cfg.stuf_flag_code);
        tok.is_stuf_esc  = (rx_byte == cfg.stuf_esc_code);
    end

endmodule

### sv/sfr_token_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_token_fifo: token queue between classifier and engine
// Small register FIFO; read data is taken straight from the head entry.
// ----------------------------------------------------------------------------
module sfr_token_fifo
    import sfr_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic wr_valid,
    output logic wr_ready,
    input  tok_t wr_data,
    output logic rd_valid,
    input  logic rd_ready,
    output tok_t rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    tok_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             wr_fire, rd_fire;

    assign wr_ready = (count_reg != CNT_FULL);
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem[rd_ptr_reg];
    assign wr_fire  = wr_valid && wr_ready;
    assign rd_fire  = rd_ready && rd_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_fire) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_fire) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_fire && !rd_fire) begin
            count_next = count_reg + 1'b1;
        end else if (rd_fire && !wr_fire) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_fire) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### sv/sfr_frame_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_frame_engine: frame state machine and result register
// Takes one token per cycle unless a result waits: header hunt, de-stuffing,
// one-byte payload delay, running XOR check and the end-of-frame verdict.
// ----------------------------------------------------------------------------
module sfr_frame_engine
    import sfr_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  cfg_t cfg,
    input  logic tok_valid,
    output logic tok_ready,
    input  tok_t tok,
    output logic res_valid,
    input  logic res_ready,
    output res_t res
);

    phase_t     phase_reg, phase_next;
    logic       frame_seq_reg, frame_seq_next;
    logic [7:0] held_byte_reg, held_byte_next;
    logic [1:0] held_cnt_reg, held_cnt_next;
    logic [7:0] run_xor_reg, run_xor_next;
    logic       exp_seq_reg, exp_seq_next;
    logic       out_valid_reg, out_valid_next;
    res_t       out_res_reg, out_res_next;

    logic       tok_fire;
    logic       body_take;
    logic [7:0] body_byte;
    logic       good;
    logic       hdr_ok;

    assign tok_ready = !out_valid_reg || res_ready;
    assign tok_fire  = tok_valid && tok_ready;
    assign res_valid = out_valid_reg;
    assign res       = out_res_reg;

    assign good   = (held_cnt_reg != 2'd0) && (run_xor_reg == held_byte_reg);
    assign hdr_ok = frame_seq_reg ? tok.is_hdr_odd : tok.is_hdr_even;

    // next phase
    always_comb begin
        phase_next = phase_reg;
        if (tok_fire) begin
            case (phase_reg)
                PH_FLAG: begin
                    if (tok.is_flag)      phase_next = PH_FLAG;
                    else if (tok.is_addr) phase_next = PH_ADDR;
                    else                  phase_next = PH_HUNT;
                end
                PH_ADDR: begin
                    if (tok.is_ctrl_even || tok.is_ctrl_odd) phase_next = PH_CTRL;
                    else phase_next = tok.is_flag ? PH_FLAG : PH_HUNT;
                end
                PH_CTRL: begin
                    if (hdr_ok) phase_next = PH_BODY;
                    else        phase_next = tok.is_flag ? PH_FLAG : PH_HUNT;
                end
                PH_BODY: begin
                    if (tok.is_flag)        phase_next = PH_FLAG;
                    else if (tok.is_escape) phase_next = PH_ESC;
                    else                    phase_next = PH_BODY;
                end
                PH_ESC: begin
                    if (tok.is_stuf_flag || tok.is_stuf_esc) phase_next = PH_BODY;
                    else phase_next = tok.is_flag ? PH_FLAG : PH_HUNT;
                end
                default: begin
                    phase_next = tok.is_flag ? PH_FLAG : PH_HUNT;
                end
            endcase
        end
    end

    // datapath and results
    always_comb begin
        frame_seq_next = frame_seq_reg;
        held_byte_next = held_byte_reg;
        held_cnt_next  = held_cnt_reg;
        run_xor_next   = run_xor_reg;
        exp_seq_next   = exp_seq_reg;
        out_valid_next = out_valid_reg && !res_ready;
        out_res_next   = out_res_reg;
        body_take      = 1'b0;
        body_byte      = tok.data;

        if (tok_fire) begin
            case (phase_reg)
                PH_ADDR: begin
                    if (tok.is_ctrl_even)     frame_seq_next = 1'b0;
                    else if (tok.is_ctrl_odd) frame_seq_next = 1'b1;
                end
                PH_CTRL: begin
                    if (hdr_ok) begin
                        held_byte_next = 8'd0;
                        held_cnt_next  = 2'd0;
                        run_xor_next   = 8'd0;
                    end
                end
                PH_BODY: begin
                    if (tok.is_flag) begin
                        out_valid_next               = 1'b1;
                        out_res_next.data_byte       = 8'd0;
                        out_res_next.seq_bit         = frame_seq_reg;
                        out_res_next.send_reply      = 1'b1;
                        out_res_next.reply_is_reject = !good;
                        out_res_next.last            = 1'b1;
                        if (!good) begin
                            out_res_next.kind = KIND_BAD_CHECK;
                        end else if (frame_seq_reg == exp_seq_reg) begin
                            out_res_next.kind = KIND_GOOD_NEW;
                            exp_seq_next      = !exp_seq_reg;
                        end else begin
                            out_res_next.kind = KIND_GOOD_DUP;
                        end
                    end else if (!tok.is_escape) begin
                        body_take = 1'b1;
                    end
                end
                PH_ESC: begin
                    if (tok.is_stuf_flag) begin
                        body_take = 1'b1;
                        body_byte = cfg.flag_code;
                    end else if (tok.is_stuf_esc) begin
                        body_take = 1'b1;
                        body_byte = cfg.escape_code;
                    end else begin
                        out_valid_next               = 1'b1;
                        out_res_next.kind            = KIND_ESC_ERROR;
                        out_res_next.data_byte       = 8'd0;
                        out_res_next.seq_bit         = frame_seq_reg;
                        out_res_next.send_reply      = 1'b0;
                        out_res_next.reply_is_reject = 1'b0;
                        out_res_next.last            = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end

        // one-byte delay: emit the held byte, keep the new one back
        if (body_take) begin
            if (held_cnt_reg != 2'd0) begin
                out_valid_next               = 1'b1;
                out_res_next.kind            = KIND_PAYLOAD;
                out_res_next.data_byte       = held_byte_reg;
                out_res_next.seq_bit         = frame_seq_reg;
                out_res_next.send_reply      = 1'b0;
                out_res_next.reply_is_reject = 1'b0;
                out_res_next.last            = 1'b0;
                run_xor_next                 = run_xor_reg ^ held_byte_reg;
            end
            held_byte_next = body_byte;
            if (held_cnt_reg != 2'd2) begin
                held_cnt_next = held_cnt_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HUNT;
            frame_seq_reg <= 1'b0;
            held_byte_reg <= 8'd0;
            held_cnt_reg  <= 2'd0;
            run_xor_reg   <= 8'd0;
            exp_seq_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            frame_seq_reg <= frame_seq_next;
            held_byte_reg <= held_byte_next;
            held_cnt_reg  <= held_cnt_next;
            run_xor_reg   <= run_xor_next;
            exp_seq_reg   <= exp_seq_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_res_reg <= out_res_next;
    end

endmodule

### sv/stuffed_frame_receiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stuffed_frame_receiver: byte-stuffed information frame receiver
// Hunts for frame headers, de-stuffs the body, streams payload bytes and
// reports a verdict with an RR/REJ request at each closing flag.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_rx_byte carry raw line bytes, one per transfer.
//   m_valid/m_ready carry results: payload bytes (kind 0) and end-of-frame
//   verdicts (kinds 1..4, m_last high). Many line bytes give no result
//   (header bytes, escapes, the first body byte, which is held back).
//   Configuration: cfg_wr_en writes cfg_wr_data into register cfg_index
//   (flag, escape, stuffed flag, stuffed escape, address, even and odd
//   control codes); indexes above six are ignored. Write only while the
//   receiver is idle.
// Throughput: one byte per cycle while results are taken. The front
//   classifier writes a token queue and the frame engine retires one token
//   per cycle unless a result waits in its output register.
// Path: the byte that causes a result is registered in the token queue,
//   and the result is then registered in the engine's output register.
// Reset: synchronous active-low aresetn returns to hunting for a flag,
//   clears the expected sequence bit and reloads the default codes.
// Stall: while a result waits and m_ready is low, the engine holds; the
//   queue then fills and s_ready drops. No byte or result is ever dropped.
// ----------------------------------------------------------------------------
module stuffed_frame_receiver
    import sfr_pkg::*;
#(
    parameter int FIFO_DEPTH = 2
) (
    input  logic       aclk,
    input  logic       aresetn,
    // configuration write port
    input  logic       cfg_wr_en,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_wr_data,
    // line byte input
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    // result output
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_kind,
    output logic [7:0] m_data_byte,
    output logic       m_seq_bit,
    output logic       m_send_reply,
    output logic       m_reply_is_reject,
    output logic       m_last
);

    cfg_t cfg_reg, cfg_next;
    tok_t in_tok;
    tok_t q_tok;
    logic q_valid;
    logic q_ready;
    res_t res;

    // configuration registers
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_FLAG_CODE:      cfg_next.flag_code      = cfg_wr_data;
                CFG_ESCAPE_CODE:    cfg_next.escape_code    = cfg_wr_data;
                CFG_STUF_FLAG_CODE: cfg_next.stuf_flag_code = cfg_wr_data;
                CFG_STUF_ESC_CODE:  cfg_next.stuf_esc_code  = cfg_wr_data;
                CFG_SENDER_ADDR:    cfg_next.sender_addr    = cfg_wr_data;
                CFG_CTRL_EVEN:      cfg_next.ctrl_even      = cfg_wr_data;
                CFG_CTRL_ODD:       cfg_next.ctrl_odd       = cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.flag_code      <= RST_FLAG_CODE;
            cfg_reg.escape_code    <= RST_ESCAPE_CODE;
            cfg_reg.stuf_flag_code <= RST_STUF_FLAG_CODE;
            cfg_reg.stuf_esc_code  <= RST_STUF_ESC_CODE;
            cfg_reg.sender_addr    <= RST_SENDER_ADDR;
            cfg_reg.ctrl_even      <= RST_CTRL_EVEN;
            cfg_reg.ctrl_odd       <= RST_CTRL_ODD;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // front end: classify each incoming byte
    sfr_classifier u_classifier (
        .rx_byte (s_rx_byte),
        .cfg     (cfg_reg),
        .tok     (in_tok)
    );

    sfr_token_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_token_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (s_valid),
        .wr_ready (s_ready),
        .wr_data  (in_tok),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_tok)
    );

    // back end: frame state machine with output register
    sfr_frame_engine u_frame_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .tok_valid (q_valid),
        .tok_ready (q_ready),
        .tok       (q_tok),
        .res_valid (m_valid),
        .res_ready (m_ready),
        .res       (res)
    );

    assign m_kind            = res.kind;
    assign m_data_byte       = res.data_byte;
    assign m_seq_bit         = res.seq_bit;
    assign m_send_reply      = res.send_reply;
    assign m_reply_is_reject = res.reply_is_reject;
    assign m_last            = res.last;

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the stuffed frame receiver
// Drives raw line bytes through the valid/ready input with random gaps,
// drains results with random back-pressure, and checks each result against
// a byte-level predictor of the frame receiver. Runs a directed opener and
// then random frames, noise and broken headers under several code sets.
// ----------------------------------------------------------------------------
module tb_top
    import sfr_pkg::*;
();

    localparam int         QUIET_LIMIT    = 1000; // cycles with no transfer at all
    localparam int         DRAIN_CYCLES   = 16;   // covers token queue plus engine
    localparam logic [2:0] CFG_UNUSED_IDX = 3'd7;

    localparam cfg_t RESET_CODES = '{RST_FLAG_CODE, RST_ESCAPE_CODE, RST_STUF_FLAG_CODE,
                                     RST_STUF_ESC_CODE, RST_SENDER_ADDR, RST_CTRL_EVEN,
                                     RST_CTRL_ODD};

    // ------------------------------------------------------------------------
    // Predictor and result store. Mirrors the receiver phase by phase and
    // queues the results each accepted line byte must produce.
    // ------------------------------------------------------------------------
    class frame_scoreboard;
        cfg_t       cfg;
        phase_t     phase;
        logic       frame_seq;
        logic       expected_seq;
        logic [7:0] held_byte;
        logic [1:0] held_count;
        logic [7:0] running_xor;
        res_t       due_results[$];
        int         errors;
        int         results_seen;

        function new(cfg_t codes);
            cfg          = codes;
            phase        = PH_HUNT;
            frame_seq    = 1'b0;
            expected_seq = 1'b0;
            held_byte    = 8'h00;
            held_count   = 2'd0;
            running_xor  = 8'h00;
            errors       = 0;
            results_seen = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [7:0] val);
            case (idx)
                CFG_FLAG_CODE:      cfg.flag_code      = val;
                CFG_ESCAPE_CODE:    cfg.escape_code    = val;
                CFG_STUF_FLAG_CODE: cfg.stuf_flag_code = val;
                CFG_STUF_ESC_CODE:  cfg.stuf_esc_code  = val;
                CFG_SENDER_ADDR:    cfg.sender_addr    = val;
                CFG_CTRL_EVEN:      cfg.ctrl_even      = val;
                CFG_CTRL_ODD:       cfg.ctrl_odd       = val;
                default:            ;
            endcase
        endfunction

        function void post_result(kind_t k, logic [7:0] d, logic send, logic rej,
                                  logic fin);
            res_t r;
            r.kind            = k;
            r.data_byte       = d;
            r.seq_bit         = frame_seq;
            r.send_reply      = send;
            r.reply_is_reject = rej;
            r.last            = fin;
            due_results.push_back(r);
        endfunction

        // body bytes go out one late so the trailing check byte never shows
        function void absorb_body(logic [7:0] d);
            if (held_count != 2'd0) begin
                post_result(KIND_PAYLOAD, held_byte, 1'b0, 1'b0, 1'b0);
                running_xor = running_xor ^ held_byte;
            end
            held_byte = d;
            if (held_count < 2'd2)
                held_count = held_count + 2'd1;
        endfunction

        function void decode_line_byte(logic [7:0] b);
            logic [7:0] ctrl;
            logic       good;
            case (phase)
                PH_FLAG: begin
                    if (b == cfg.flag_code)        phase = PH_FLAG;
                    else if (b == cfg.sender_addr) phase = PH_ADDR;
                    else                           phase = PH_HUNT;
                end
                PH_ADDR: begin
                    if (b == cfg.ctrl_even) begin
                        frame_seq = 1'b0;
                        phase     = PH_CTRL;
                    end else if (b == cfg.ctrl_odd) begin
                        frame_seq = 1'b1;
                        phase     = PH_CTRL;
                    end else begin
                        phase = (b == cfg.flag_code) ? PH_FLAG : PH_HUNT;
                    end
                end
                PH_CTRL: begin
                    ctrl = frame_seq ? cfg.ctrl_odd : cfg.ctrl_even;
                    if (b == (cfg.sender_addr ^ ctrl)) begin
                        phase       = PH_BODY;
                        held_byte   = 8'h00;
                        held_count  = 2'd0;
                        running_xor = 8'h00;
                    end else begin
                        phase = (b == cfg.flag_code) ? PH_FLAG : PH_HUNT;
                    end
                end
                PH_BODY: begin
                    if (b == cfg.flag_code) begin
                        good = (held_count != 2'd0) && (running_xor == held_byte);
                        if (!good) begin
                            post_result(KIND_BAD_CHECK, 8'h00, 1'b1, 1'b1, 1'b1);
                        end else if (frame_seq == expected_seq) begin
                            post_result(KIND_GOOD_NEW, 8'h00, 1'b1, 1'b0, 1'b1);
                            expected_seq = ~expected_seq;
                        end else begin
                            post_result(KIND_GOOD_DUP, 8'h00, 1'b1, 1'b0, 1'b1);
                        end
                        phase = PH_FLAG;   // closing flag also opens the next frame
                    end else if (b == cfg.escape_code) begin
                        phase = PH_ESC;
                    end else begin
                        absorb_body(b);
                    end
                end
                PH_ESC: begin
                    if (b == cfg.stuf_flag_code) begin
                        phase = PH_BODY;
                        absorb_body(cfg.flag_code);
                    end else if (b == cfg.stuf_esc_code) begin
                        phase = PH_BODY;
                        absorb_body(cfg.escape_code);
                    end else begin
                        post_result(KIND_ESC_ERROR, 8'h00, 1'b0, 1'b0, 1'b1);
                        phase = (b == cfg.flag_code) ? PH_FLAG : PH_HUNT;
                    end
                end
                default: begin
                    phase = (b == cfg.flag_code) ? PH_FLAG : PH_HUNT;
                end
            endcase
        endfunction

        task report(string what);
            errors++;
            $display("ERROR @%0t: %s", $time, what);
        endtask

        task check_result(res_t got);
            res_t  want;
            string diff;
            if (due_results.size() == 0) begin
                report($sformatf("unpredicted result kind %0d data %02h",
                                 got.kind, got.data_byte));
                return;
            end
            want = due_results.pop_front();
            diff = "";
            if (got.kind !== want.kind)
                diff = {diff, $sformatf(" kind %0d exp %0d", got.kind, want.kind)};
            if (got.data_byte !== want.data_byte)
                diff = {diff, $sformatf(" data %02h exp %02h", got.data_byte,
                                        want.data_byte)};
            if (got.seq_bit !== want.seq_bit)
                diff = {diff, $sformatf(" seq %b exp %b", got.seq_bit, want.seq_bit)};
            if (got.send_reply !== want.send_reply)
                diff = {diff, $sformatf(" reply %b exp %b", got.send_reply,
                                        want.send_reply)};
            if (got.reply_is_reject !== want.reply_is_reject)
                diff = {diff, $sformatf(" rej %b exp %b", got.reply_is_reject,
                                        want.reply_is_reject)};
            if (got.last !== want.last)
                diff = {diff, $sformatf(" last %b exp %b", got.last, want.last)};
            if (diff != "")
                report($sformatf("result %0d:%s", results_seen, diff));
            results_seen++;
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and DUT. All inputs start at known values.
    // ------------------------------------------------------------------------
    logic       aclk;
    logic       aresetn     = 1'b0;
    logic       cfg_wr_en   = 1'b0;
    logic [2:0] cfg_index   = 3'd0;
    logic [7:0] cfg_wr_data = 8'h00;
    logic       s_valid     = 1'b0;
    logic       s_ready;
    logic [7:0] s_rx_byte   = 8'h00;
    logic       m_valid;
    logic       m_ready     = 1'b0;
    logic [2:0] m_kind;
    logic [7:0] m_data_byte;
    logic       m_seq_bit;
    logic       m_send_reply;
    logic       m_reply_is_reject;
    logic       m_last;

    frame_scoreboard sb;
    res_t            seen_result;
    int              quiet_cycles  = 0;
    int              line_bytes    = 0;     // line bytes transferred so far
    bit              src_calm      = 1'b0;  // sender runs back to back
    bit              snk_calm      = 1'b0;  // receiver never stalls
    bit              last_was_flag = 1'b0;
    logic            tx_seq        = 1'b0;  // sequence the sender believes is due

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    stuffed_frame_receiver i_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_rx_byte         (s_rx_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_kind            (m_kind),
        .m_data_byte       (m_data_byte),
        .m_seq_bit         (m_seq_bit),
        .m_send_reply      (m_send_reply),
        .m_reply_is_reject (m_reply_is_reject),
        .m_last            (m_last)
    );

    always_comb begin
        seen_result.kind            = kind_t'(m_kind);
        seen_result.data_byte       = m_data_byte;
        seen_result.seq_bit         = m_seq_bit;
        seen_result.send_reply      = m_send_reply;
        seen_result.reply_is_reject = m_reply_is_reject;
        seen_result.last            = m_last;
    end

    // ------------------------------------------------------------------------
    // Monitor: both channels sampled at the edge, pre-update values only.
    // A result transfer always stems from an earlier byte, so the order of
    // the two checks below does not matter.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                sb.check_result(seen_result);
            if (s_valid && s_ready)
                sb.decode_line_byte(s_rx_byte);
        end
    end

    // Watchdog: a hung handshake or a lost result stops the transfers.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("ERROR: no transfer for %0d cycles", QUIET_LIMIT);
                $display("tb_top: FAIL");
                $finish;
            end
        end
    end

    // At least half the draws are zero so the queue sees full and empty spells.
    function automatic int draw_wait(bit calm);
        if (calm || $urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(0, 13);
    endfunction

    // Result side: random stall before each transfer, ready held until taken.
    initial begin : result_sink
        int stall;
        do @(posedge aclk); while (!aresetn);
        forever begin
            stall = draw_wait(snk_calm);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // ------------------------------------------------------------------------
    // Line side drivers
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = draw_wait(src_calm);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        last_was_flag = (b == sb.cfg.flag_code);
        line_bytes++;
    endtask

    // escape any body byte that collides with the flag or escape code
    task automatic send_stuffed(input logic [7:0] d);
        if (d == sb.cfg.flag_code) begin
            send_byte(sb.cfg.escape_code);
            send_byte(sb.cfg.stuf_flag_code);
        end else if (d == sb.cfg.escape_code) begin
            send_byte(sb.cfg.escape_code);
            send_byte(sb.cfg.stuf_esc_code);
        end else begin
            send_byte(d);
        end
    endtask

    task automatic send_header(input logic seq);
        logic [7:0] ctrl;
        ctrl = seq ? sb.cfg.ctrl_odd : sb.cfg.ctrl_even;
        send_byte(sb.cfg.sender_addr);
        send_byte(ctrl);
        send_byte(sb.cfg.sender_addr ^ ctrl);
    endtask

    // Result queue is checked on the falling edge, away from the monitor,
    // then the driver lines up with the rising edge again.
    task automatic hold_until_drained();
        s_valid <= 1'b0;
        do @(negedge aclk); while (sb.due_results.size() != 0);
        @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        sb.set_reg(idx, val);
        @(posedge aclk);
    endtask

    // Block must be idle: no byte in flight, no result outstanding.
    task automatic write_config(input cfg_t c);
        write_reg(CFG_FLAG_CODE,      c.flag_code);
        write_reg(CFG_ESCAPE_CODE,    c.escape_code);
        write_reg(CFG_STUF_FLAG_CODE, c.stuf_flag_code);
        write_reg(CFG_STUF_ESC_CODE,  c.stuf_esc_code);
        write_reg(CFG_SENDER_ADDR,    c.sender_addr);
        write_reg(CFG_CTRL_EVEN,      c.ctrl_even);
        write_reg(CFG_CTRL_ODD,       c.ctrl_odd);
        write_reg(CFG_UNUSED_IDX,     8'($urandom));   // must be ignored
        cfg_wr_en <= 1'b0;
    endtask

    // A third are code bytes so that stuffing and header paths get hit often.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 11))
            0:       return sb.cfg.flag_code;
            1:       return sb.cfg.escape_code;
            2:       return sb.cfg.stuf_flag_code;
            3:       return sb.cfg.stuf_esc_code;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic cfg_t random_codes(bit distinct);
        cfg_t c;
        c.flag_code      = 8'($urandom);
        c.escape_code    = 8'($urandom);
        c.stuf_flag_code = 8'($urandom);
        c.stuf_esc_code  = 8'($urandom);
        c.sender_addr    = 8'($urandom);
        c.ctrl_even      = 8'($urandom);
        c.ctrl_odd       = 8'($urandom);
        if (distinct) begin
            while (c.escape_code == c.flag_code)
                c.escape_code = 8'($urandom);
            while (c.stuf_flag_code == c.flag_code || c.stuf_flag_code == c.escape_code)
                c.stuf_flag_code = 8'($urandom);
            while (c.stuf_esc_code == c.flag_code || c.stuf_esc_code == c.escape_code ||
                   c.stuf_esc_code == c.stuf_flag_code)
                c.stuf_esc_code = 8'($urandom);
            while (c.ctrl_odd == c.ctrl_even)
                c.ctrl_odd = 8'($urandom);
        end
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    // Well-formed frame with random body; a few carry a bad check, a broken
    // escape pair, a missing check byte or the wrong sequence number.
    task automatic send_frame();
        logic       seq;
        logic [7:0] chk;
        int         len;
        bit         bad_esc;
        bit         no_chk;
        bit         corrupt;
        seq     = ($urandom_range(0, 4) != 0) ? tx_seq : ~tx_seq;
        len     = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
        bad_esc = ($urandom_range(0, 11) == 0);
        no_chk  = ($urandom_range(0, 19) == 0);
        corrupt = ($urandom_range(0, 9) == 0);
        // back-to-back frames may share one flag
        if (!last_was_flag || $urandom_range(0, 3) == 0)
            send_byte(sb.cfg.flag_code);
        send_header(seq);
        chk = 8'h00;
        repeat (len) begin
            logic [7:0] d;
            d   = pick_byte();
            chk = chk ^ d;
            send_stuffed(d);
        end
        if (bad_esc) begin
            send_byte(sb.cfg.escape_code);
            send_byte(pick_byte());
        end
        if (!no_chk) begin
            if (corrupt)
                chk = chk ^ 8'($urandom_range(1, 255));
            send_stuffed(chk);
        end
        send_byte(sb.cfg.flag_code);
        if (!bad_esc && !no_chk && !corrupt && seq == tx_seq)
            tx_seq = ~tx_seq;
    endtask

    task automatic run_sequence();
        int pick;
        int n;
        if ($urandom_range(0, 9) == 0)
            src_calm = !src_calm;
        if ($urandom_range(0, 9) == 0)
            snk_calm = !snk_calm;
        // now and then let everything drain before going on
        if ($urandom_range(0, 29) == 0)
            hold_until_drained();
        pick = $urandom_range(0, 99);
        if (pick < 72) begin
            send_frame();
        end else if (pick < 86) begin
            n = $urandom_range(1, 8);
            repeat (n) send_byte(pick_byte());
        end else begin
            // header cut short by a wrong control or a wrong header check
            send_byte(sb.cfg.flag_code);
            send_byte(sb.cfg.sender_addr);
            if (pick < 93) begin
                send_byte(pick_byte());
            end else begin
                send_byte(sb.cfg.ctrl_even);
                send_byte(pick_byte());
            end
        end
    endtask

    task automatic run_phase(input int n);
        int stop_at;
        stop_at = line_bytes + n;
        while (line_bytes < stop_at)
            run_sequence();
    endtask

    task automatic reconfigure(input cfg_t c, input int n);
        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);  // bytes with no result may linger
        write_config(c);
        run_phase(n);
    endtask

    // Directed opener under the reset codes: every result kind, stuffed body
    // bytes, 0x00/0xFF data, empty body, one-byte body, a duplicate, an
    // escape followed by the flag, and a flag in the control position.
    task automatic run_directed();
        send_byte(RST_FLAG_CODE);
        send_header(1'b0);
        send_stuffed(RST_FLAG_CODE);
        send_stuffed(RST_ESCAPE_CODE);
        send_stuffed(8'hFF);
        send_stuffed(RST_FLAG_CODE ^ RST_ESCAPE_CODE ^ 8'hFF);
        send_byte(RST_FLAG_CODE);          // good new frame, seq 0
        send_header(1'b1);
        send_byte(RST_FLAG_CODE);          // empty body: bad check
        send_header(1'b0);
        send_byte(8'h00);                  // lone check byte of an empty payload
        send_byte(RST_FLAG_CODE);          // good but seq 0 again: duplicate
        send_header(1'b1);
        send_byte(RST_ESCAPE_CODE);
        send_byte(RST_FLAG_CODE);          // escape error, flag reopens
        send_byte(RST_SENDER_ADDR);
        send_byte(RST_FLAG_CODE);          // header dropped at the control byte
    endtask

    initial begin : main
        sb = new(RESET_CODES);
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_config(RESET_CODES);
        run_directed();
        tx_seq = 1'b1;                     // one new frame went through above
        run_phase(250);

        // extremes, including a stuffed flag code equal to the flag itself
        reconfigure('{8'h00, 8'hFF, 8'h01, 8'hFE, 8'hFF, 8'h00, 8'h80}, 250);
        reconfigure('{8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h01}, 250);
        // colliding codes: flag beats escape, even beats odd
        reconfigure('{8'h7E, 8'h7E, 8'h5E, 8'h5E, 8'h03, 8'h22, 8'h22}, 150);
        reconfigure(random_codes(1'b1), 300);
        reconfigure(random_codes(1'b1), 300);
        reconfigure(random_codes(1'b0), 300);

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.due_results.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.due_results.size()));
        if (sb.errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
